// ===== hw/rtl/fcv_pkg.sv =====
`default_nettype none

package fcv_pkg;

  // Fixed field widths of the command and result beats
  localparam int VALUE_W   = 16;
  localparam int TAP_IDX_W = 10;
  localparam int TAP_CNT_W = 11;
  localparam int SUM_W     = 42;

  // Configuration register indexes
  localparam int REG_TAP_COUNT = 0;

  // Command codes; the spare code falls to a default arm
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_PUSH  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // Decoded operation handed from the front to the back
  typedef struct packed {
    cmd_t                        kind;
    logic [TAP_IDX_W-1:0]        index;
    logic signed [VALUE_W-1:0]   value;
  } op_t;

endpackage

`default_nettype wire

// ===== hw/rtl/direct_form_convolution_core.sv =====
`default_nettype none

// Streaming direct-form FIR convolution. Command beats load a coefficient
// (command 0), push a Q1.15 sample (command 1, one 42-bit Q12.30 sum out) or
// clear the sample history (command 2); code 3 and loads at or past MAX_TAPS
// are taken and dropped. A front decoder feeds a two-entry queue, so up to
// two commands are accepted while the back end is busy or a sum waits. In the
// back end a load or clear is done as it leaves the queue; a push writes
// the history likewise, then sweeps the taps through one multiply-accumulate
// unit that reads one coefficient and one history word per cycle; the RAM
// read and pipeline registers drain before the sum is registered. A clear
// needs no sweep: a fill count marks older history as zero. tap_count sits
// at byte address 0 of the APB port; 0 acts as 1 and values above MAX_TAPS
// act as MAX_TAPS. Write it only while the block is idle.

module direct_form_convolution_core
  import fcv_pkg::*;
#(
  parameter int MAX_TAPS    = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // APB configuration
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  // Command channel
  input  wire logic                       cmd_valid,
  output logic                            cmd_stall,
  input  wire logic [1:0]                 command,
  input  wire logic [TAP_IDX_W-1:0]       tap_index,
  input  wire logic signed [VALUE_W-1:0]  value,
  // Result channel
  output logic                            sum_valid,
  input  wire logic                       sum_stall,
  output logic signed [SUM_W-1:0]         filtered_sum
);

  localparam int CW = $clog2(MAX_TAPS + 1);

  logic [TAP_CNT_W-1:0] tap_count;
  logic [CW-1:0]        taps;
  logic                 cfg_wr;
  logic                 q_push;
  op_t                  q_push_op;
  logic                 q_full;
  logic                 q_pop;
  op_t                  q_head_op;
  logic                 q_empty;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_CNT_W'(1);
    end else if (cfg_wr && (32'(paddr[2]) == REG_TAP_COUNT)) begin
      tap_count <= pwdata[TAP_CNT_W-1:0];
    end
  end

  always_comb begin
    if (32'(paddr[2]) == REG_TAP_COUNT) begin
      prdata = 32'(tap_count);
    end else begin
      prdata = '0;
    end
  end

  // Clamp the tap count to 1..MAX_TAPS
  always_comb begin
    if (tap_count == '0) begin
      taps = CW'(1);
    end else if (32'(tap_count) > MAX_TAPS) begin
      taps = CW'(MAX_TAPS);
    end else begin
      taps = CW'(tap_count);
    end
  end

  fcv_front #(.MAX_TAPS(MAX_TAPS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .command   (command),
    .tap_index (tap_index),
    .value     (value),
    .push      (q_push),
    .push_op   (q_push_op),
    .full      (q_full)
  );

  fcv_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (q_push_op),
    .full    (q_full),
    .pop     (q_pop),
    .head_op (q_head_op),
    .empty   (q_empty)
  );

  fcv_back #(.MAX_TAPS(MAX_TAPS), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .taps         (taps),
    .head_op      (q_head_op),
    .empty        (q_empty),
    .pop          (q_pop),
    .sum_valid    (sum_valid),
    .sum_stall    (sum_stall),
    .filtered_sum (filtered_sum)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/fcv_ram.sv =====
`default_nettype none

module fcv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fcv_queue.sv =====
`default_nettype none

module fcv_queue
  import fcv_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire op_t  push_op,
  output logic      full,
  input  wire logic pop,
  output op_t       head_op,
  output logic      empty
);

  // Two-entry queue between front and back
  op_t        slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign head_op = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        slots[wr_ptr] <= push_op;
        wr_ptr        <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fcv_front.sv =====
`default_nettype none

module fcv_front
  import fcv_pkg::*;
#(
  parameter int MAX_TAPS    = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                        cmd_valid,
  output logic                             cmd_stall,
  input  wire logic [1:0]                  command,
  input  wire logic [TAP_IDX_W-1:0]        tap_index,
  input  wire logic signed [VALUE_W-1:0]   value,
  output logic                             push,
  output op_t                              push_op,
  input  wire logic                        full
);

  localparam int SW    = (SAMPLE_BITS < VALUE_W) ? SAMPLE_BITS : VALUE_W;
  localparam int SHIFT = VALUE_W - SW;

  logic signed [VALUE_W-1:0] shifted;
  logic                      keep;

  // Stall only when the queue has no room
  assign cmd_stall = full;

  // Sign-extend the value from its low SW bits
  assign shifted = value <<< SHIFT;

  always_comb begin
    push_op.kind  = cmd_t'(command);
    push_op.index = tap_index;
    push_op.value = shifted >>> SHIFT;
    unique case (command)
      CMD_LOAD:  keep = (32'(tap_index) < MAX_TAPS);
      CMD_PUSH:  keep = 1'b1;
      CMD_CLEAR: keep = 1'b1;
      default:   keep = 1'b0;
    endcase
  end

  // Beats that do nothing are taken and dropped here
  assign push = cmd_valid && !full && keep;

endmodule

`default_nettype wire

// ===== hw/rtl/fcv_back.sv =====
`default_nettype none

module fcv_back
  import fcv_pkg::*;
#(
  parameter int MAX_TAPS    = 1024,
  parameter int SAMPLE_BITS = 16,
  localparam int CW = $clog2(MAX_TAPS + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [CW-1:0]           taps,
  input  wire op_t                     head_op,
  input  wire logic                    empty,
  output logic                         pop,
  output logic                         sum_valid,
  input  wire logic                    sum_stall,
  output logic signed [SUM_W-1:0]      filtered_sum
);

  localparam int SW = (SAMPLE_BITS < VALUE_W) ? SAMPLE_BITS : VALUE_W;
  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_MAC, S_DONE} state_t;

  state_t                   state;
  logic [AW-1:0]            head;
  logic [AW-1:0]            head_inc;
  logic [CW-1:0]            fill;
  logic [CW-1:0]            cnt;
  logic [AW-1:0]            pos;
  logic                     s1_v;
  logic                     s1_h;
  logic                     s2_v;
  logic signed [2*SW-1:0]   prod;
  logic signed [SUM_W-1:0]  acc;
  logic                     issue;
  logic                     coef_we;
  logic                     hist_we;
  logic signed [SW-1:0]     coef_rd;
  logic signed [SW-1:0]     hist_rd;
  logic signed [SW-1:0]     hist_term;
  logic                     out_free;

  assign head_inc = (head == AW'(MAX_TAPS - 1)) ? '0 : head + AW'(1);
  assign issue    = (state == S_MAC) && (cnt < taps);
  assign pop      = (state == S_IDLE) && !empty;
  assign coef_we  = pop && (head_op.kind == CMD_LOAD);
  assign hist_we  = pop && (head_op.kind == CMD_PUSH);
  assign out_free = !sum_valid || !sum_stall;

  // Coefficients, indexed by tap
  fcv_ram #(.WIDTH(SW), .DEPTH(MAX_TAPS)) u_coef (
    .clk   (clk),
    .we    (coef_we),
    .waddr (AW'(head_op.index)),
    .wdata (head_op.value[SW-1:0]),
    .raddr (cnt[AW-1:0]),
    .rdata (coef_rd)
  );

  // Circular sample history; entries older than the fill count read as zero
  fcv_ram #(.WIDTH(SW), .DEPTH(MAX_TAPS)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (head_inc),
    .wdata (head_op.value[SW-1:0]),
    .raddr (pos),
    .rdata (hist_rd)
  );

  assign hist_term = s1_h ? hist_rd : '0;

  // Sequencer, MAC pipeline and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      fill      <= '0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      sum_valid <= 1'b0;
    end else begin
      s1_v <= issue;
      s1_h <= (cnt < fill);
      s2_v <= s1_v;
      prod <= coef_rd * hist_term;
      // A sum leaving with no new one behind it
      if (sum_valid && !sum_stall && (state != S_DONE)) begin
        sum_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            unique case (head_op.kind)
              CMD_CLEAR: begin
                head <= '0;
                fill <= '0;
              end
              CMD_PUSH: begin
                head  <= head_inc;
                pos   <= head_inc;
                fill  <= (fill == CW'(MAX_TAPS)) ? fill : fill + CW'(1);
                cnt   <= '0;
                acc   <= '0;
                state <= S_MAC;
              end
              default: begin
              end
            endcase
          end
        end
        S_MAC: begin
          if (issue) begin
            cnt <= cnt + CW'(1);
            pos <= (pos == '0) ? AW'(MAX_TAPS - 1) : pos - AW'(1);
          end
          if (s2_v) begin
            acc <= acc + SUM_W'(prod);
          end
          if (!issue && !s1_v && !s2_v) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            sum_valid    <= 1'b1;
            filtered_sum <= acc;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
